>>> hw/rtl/iscc_pkg.sv
// ----------------------------------------------------------------------------
// iscc_pkg: shared types and constants for the interval cover count unit
// Widths of the point store, the interval ends and the square root datapath.
// ----------------------------------------------------------------------------
package iscc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int RAD_W   = COORD_BITS - 1;
    localparam int ABS_W   = COORD_BITS + 1;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int RAD_D_W = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = RAD_D_W / 2;
    localparam int SQRT_STEPS = RAD_D_W / 2;
    localparam int STEP_W  = $clog2(SQRT_STEPS + 1);
    localparam int END_W   = COORD_BITS + FRAC_BITS + 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_R,
        ST_MUL_Y,
        ST_SQRT,
        ST_WRITE,
        ST_SCAN,
        ST_PASS_END,
        ST_OUT
    } iscc_state_t;

endpackage

>>> hw/rtl/interval_stabbing_cover_count_unit.sv
// ----------------------------------------------------------------------------
// interval_stabbing_cover_count_unit: fewest axis positions covering points
// Loads points, turns each into an interval on the x axis, then counts
// the fewest stabbing positions with a greedy minimum-right-end search.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one point per item (x, y in tdata, tlast on the
//   final point of a set). cfg_we/cfg_wdata write the coverage radius.
//   m_* channel returns one item per set: position count and the
//   unreachable flag, produced after the item that carries tlast.
// Sequence:
//   A reachable point passes the accept state, the shared 17x17 multiplier
//   (r*r, then y*y), the digit-by-digit square root (one result bit per two
//   radicand bits) and one store write. An unreachable or dropped point is
//   taken without a multiplier or root step. After the last point the sweep
//   reads the single-port point memory once per placed position plus one
//   final pass, then the result item follows; an empty set goes straight to
//   the result.
// Reset and stall:
//   aresetn clears the set (no points, flag low) and sets the radius to 1.
//   The point memory needs no clearing: only entries of the current set are
//   read. A stalled result holds on m_tdata; no point is taken until the
//   result is delivered.
// ----------------------------------------------------------------------------
module interval_stabbing_cover_count_unit
    import iscc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [RAD_W-1:0]           cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [2*COORD_BITS-1:0]    s_tdata,   // point_x, point_y
    input  logic                       s_tlast,   // is_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // position_count, unreachable, zeros
);

    iscc_state_t state_reg, state_next;

    logic [RAD_W-1:0]            radius_reg;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic [ABS_W-1:0]            ay_reg, ay_next;
    logic                        last_reg, last_next;
    logic [SQ_W-1:0]             rr_reg, rr_next;
    logic [RAD_D_W-1:0]          v_reg, v_next;
    logic [RAD_D_W-1:0]          res_reg, res_next;
    logic [RAD_D_W-1:0]          bit_reg, bit_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [CNT_W-1:0]            loaded_reg, loaded_next;
    logic                        far_reg, far_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [END_W-1:0]     lastpos_reg, lastpos_next;
    logic [CNT_W-1:0]            scan_idx_reg, scan_idx_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic                        rd_last_reg, rd_last_next;
    logic                        found_reg, found_next;
    logic signed [END_W-1:0]     min_reg, min_next;
    logic [2*END_W-1:0]          q_reg;

    logic [2*END_W-1:0]          mem [MAX_POINTS];

    logic                        in_take;
    logic [ABS_W-1:0]            in_ay;
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic [ABS_W-1:0]            mul_a;
    logic [2*ABS_W-1:0]          mul_b;
    logic [2*ABS_W-1:0]          product;
    logic [RAD_D_W-1:0]          trial;
    logic signed [END_W-1:0]     cx, half, left_end, right_end;
    logic signed [END_W-1:0]     q_left, q_right;
    logic                        issue, mem_we;
    logic                        uncovered;

    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_take = s_tvalid && s_tready;
    assign in_ay   = in_y[COORD_BITS-1] ? ABS_W'(-$signed({in_y[COORD_BITS-1], in_y}))
                                         : ABS_W'({1'b0, in_y});

    // shared multiplier: r*r first, then |y|*|y|
    assign mul_a   = (state_reg == ST_MUL_R) ? ABS_W'(radius_reg) : ay_reg;
    assign product = mul_a * mul_a;
    assign mul_b   = product;

    assign trial = res_reg + bit_reg;

    // interval ends from the settled root
    assign cx        = END_W'(x_reg) <<< FRAC_BITS;
    assign half      = END_W'(res_reg[ROOT_W-1:0]);
    assign left_end  = cx - half;
    assign right_end = cx + half;

    assign q_left    = q_reg[END_W-1:0];
    assign q_right   = q_reg[2*END_W-1:END_W];
    assign uncovered = (count_reg == '0) || (q_left > lastpos_reg);

    assign issue  = (state_reg == ST_SCAN) && (scan_idx_reg < loaded_reg);
    assign mem_we = (state_reg == ST_WRITE);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = OUT_DATA_W'({far_reg, count_reg});

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        ay_next       = ay_reg;
        last_next     = last_reg;
        rr_next       = rr_reg;
        v_next        = v_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        step_next     = step_reg;
        loaded_next   = loaded_reg;
        far_next      = far_reg;
        count_next    = count_reg;
        lastpos_next  = lastpos_reg;
        scan_idx_next = scan_idx_reg;
        rd_pend_next  = issue;
        rd_last_next  = issue && (scan_idx_reg + CNT_W'(1) == loaded_reg);
        found_next    = found_reg;
        min_next      = min_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    x_next    = in_x;
                    ay_next   = in_ay;
                    last_next = s_tlast;
                    if (in_ay > ABS_W'(radius_reg)) begin
                        // out of reach: flag it, store nothing
                        far_next   = 1'b1;
                        state_next = s_tlast ? ST_SCAN : ST_IDLE;
                    end else if (loaded_reg >= CNT_W'(MAX_POINTS)) begin
                        // store full: drop the point
                        state_next = s_tlast ? ST_SCAN : ST_IDLE;
                    end else begin
                        state_next = ST_MUL_R;
                    end
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                end
            end
            ST_MUL_R: begin
                rr_next    = SQ_W'(mul_b);
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                v_next     = RAD_D_W'(rr_reg - SQ_W'(mul_b)) << (2 * FRAC_BITS);
                res_next   = '0;
                bit_next   = RAD_D_W'(1) << (RAD_D_W - 2);
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (v_reg >= trial) begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                loaded_next = loaded_reg + CNT_W'(1);
                state_next  = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (loaded_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    if (issue) begin
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                    // keep the smallest right end among uncovered intervals
                    if (rd_pend_reg && uncovered && (!found_reg || q_right < min_reg)) begin
                        found_next = 1'b1;
                        min_next   = q_right;
                    end
                    if (rd_pend_reg && rd_last_reg) begin
                        state_next = ST_PASS_END;
                    end
                end
            end
            ST_PASS_END: begin
                if (found_reg) begin
                    // place a position at that right end and sweep again
                    lastpos_next  = min_reg;
                    count_next    = count_reg + CNT_W'(1);
                    found_next    = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    loaded_next = '0;
                    far_next    = 1'b0;
                    count_next  = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            radius_reg   <= RAD_W'(1);
            loaded_reg   <= '0;
            far_reg      <= 1'b0;
            count_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                radius_reg <= cfg_wdata;
            end
            loaded_reg   <= loaded_next;
            far_reg      <= far_next;
            count_reg    <= count_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            found_reg    <= found_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        ay_reg      <= ay_next;
        last_reg    <= last_next;
        rr_reg      <= rr_next;
        v_reg       <= v_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        step_reg    <= step_next;
        lastpos_reg <= lastpos_next;
        min_reg     <= min_next;
    end

    // point memory: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[loaded_reg[IDX_W-1:0]] <= {right_end, left_end};
        end
        if (issue) begin
            q_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

>>> tb/interval_stabbing_cover_count_checker.sv
// ----------------------------------------------------------------------------
// interval_stabbing_cover_count_checker: result predictor and comparator
// Watches the point and result channels and the radius writes, keeps its
// own copy of the point set, and predicts the stabbing count and flag per set.
// ----------------------------------------------------------------------------
module interval_stabbing_cover_count_checker
    import iscc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [RAD_W-1:0]        cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [2*COORD_BITS-1:0] s_tdata,
    input  logic                    s_tlast,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    output int                      fail_count,
    output int                      pending_sets
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       too_far;
        logic [10:0] count;
    } cover_result_t;

    logic [RAD_W-1:0] radius;
    longint           lo_end [$];
    longint           hi_end [$];
    logic             far_seen;
    cover_result_t    expected_covers [$];

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Greedy sweep over intervals ordered by right end.
    function automatic int count_stabs();
        longint lo [$], hi [$];
        longint lk, rk, last_pos;
        int j, placed;
        lo = lo_end;
        hi = hi_end;
        for (int i = 1; i < hi.size(); i++) begin
            lk = lo[i];
            rk = hi[i];
            j = i;
            while (j > 0 && hi[j-1] > rk) begin
                lo[j] = lo[j-1];
                hi[j] = hi[j-1];
                j--;
            end
            lo[j] = lk;
            hi[j] = rk;
        end
        placed = 0;
        last_pos = 0;
        for (int i = 0; i < hi.size(); i++) begin
            if (placed == 0 || lo[i] > last_pos) begin
                last_pos = hi[i];
                placed++;
            end
        end
        return placed;
    endfunction

    always @(posedge aclk) begin
        longint px, py, ay, h, cx;
        longint unsigned rad_d;
        cover_result_t got, want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            radius <= 1;
            lo_end.delete();
            hi_end.delete();
            far_seen = 0;
            fail_count <= 0;
        end else begin
            if (cfg_we) radius <= cfg_wdata;
            if (s_tvalid && s_tready) begin
                px = longint'($signed(s_tdata[COORD_BITS-1:0]));
                py = longint'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
                ay = py < 0 ? -py : py;
                if (ay > longint'(radius)) begin
                    far_seen = 1;
                end else if (hi_end.size() < MAX_POINTS) begin
                    rad_d = longint'(radius) * longint'(radius) - ay * ay;
                    h = int_sqrt(rad_d << (2 * FRAC_BITS));
                    cx = px * (longint'(1) << FRAC_BITS);
                    lo_end = {lo_end, cx - h};
                    hi_end = {hi_end, cx + h};
                end
                if (s_tlast) begin
                    want.count = 11'(count_stabs());
                    want.too_far = far_seen;
                    expected_covers = {expected_covers, want};
                    lo_end.delete();
                    hi_end.delete();
                    far_seen = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[11], m_tdata[10:0]};
                if (expected_covers.size() == 0) begin
                    $error("result item with no set pending: %h", m_tdata);
                    errs++;
                end else begin
                    want = expected_covers.pop_front();
                    if (got.count !== want.count) begin
                        $error("position_count: expected %0d, got %0d",
                               want.count, got.count);
                        errs++;
                    end
                    if (got.too_far !== want.too_far) begin
                        $error("unreachable: expected %0d, got %0d",
                               want.too_far, got.too_far);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
        pending_sets = expected_covers.size();
    end
endmodule

>>> tb/interval_stabbing_cover_count_unit_test.sv
// ----------------------------------------------------------------------------
// interval_stabbing_cover_count_unit_test: stimulus and verdict
// Loads point sets under several coverage radii, with random gaps on the
// point channel and random back-pressure on the result channel.
// ----------------------------------------------------------------------------
module interval_stabbing_cover_count_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import iscc_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic                    aclk = 0;
    logic                    aresetn = 0;
    logic                    cfg_we = 0;
    logic [RAD_W-1:0]        cfg_wdata = '0;
    logic                    s_tvalid = 0;
    logic                    s_tready;
    logic [2*COORD_BITS-1:0] s_tdata = '0;
    logic                    s_tlast = 0;
    logic                    m_tvalid;
    logic                    m_tready = 0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    int                      fail_count;
    int                      pending_sets;
    int                      quiet_cycles = 0;
    int                      point_total = 0;

    always #5 aclk = ~aclk;

    interval_stabbing_cover_count_unit uut (.*);

    interval_stabbing_cover_count_checker checker_i (.*);

    // Watchdog: count cycles with no item moving on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: a random stall before each accepted item.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Offer one point, hold until accepted; random gap beforehand.
    task automatic send_point(input logic signed [15:0] px,
                              input logic signed [15:0] py, input logic last);
        int gap;
        gap = $urandom_range(0, 3);
        if (point_total % 40 < 10) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {py, px};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        point_total++;
    endtask

    // Drain all results, let the block settle, then write a new radius.
    task automatic set_radius(input logic [RAD_W-1:0] r);
        s_tvalid <= 0;
        while (pending_sets != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= r;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // A set of n random points with y within reach mostly.
    task automatic random_set(input int n, input logic [RAD_W-1:0] r);
        logic signed [15:0] px, py;
        int span;
        for (int i = 0; i < n; i++) begin
            span = $urandom_range(0, 3) == 0 ? 32767 : 4 * int'(r) + 16;
            if (span > 32767) span = 32767;
            px = 16'($signed($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 9) == 0)
                py = 16'($urandom);
            else
                py = 16'($signed($urandom_range(0, 2 * r)) - int'(r));
            send_point(px, py, i == n - 1);
        end
    endtask

    initial begin
        logic [RAD_W-1:0] radii [6];
        radii = '{15'd0, 15'd32767, 15'd5, 15'd100, 15'd2000, 15'd1};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: reset radius, extremes, touching intervals, empty set.
        send_point(16'sh7fff, 16'sh0000, 0);
        send_point(-16'sh8000, 16'sh0001, 0);
        send_point(16'sh0000, -16'sh0001, 0);
        send_point(16'sh0002, 16'sh0000, 0);   // interval x=1..3, touches the next at x=3
        send_point(16'sh0004, 16'sh0000, 1);
        send_point(16'sh0000, -16'sh8000, 1);  // only an out-of-reach point
        send_point(16'sh0000, 16'sh7fff, 0);
        send_point(16'sh0010, 16'sh0000, 1);
        set_radius(15'd32767);
        send_point(16'sh7fff, 16'sh7fff, 0);
        send_point(-16'sh8000, -16'sh7fff, 0);
        send_point(16'sh1234, -16'sh8000, 0);
        send_point(-16'sh5555, 16'sh0000, 1);
        set_radius(15'd0);
        send_point(16'sh0003, 16'sh0000, 0);
        send_point(16'sh0003, 16'sh0000, 0);
        send_point(16'sh0004, 16'sh0001, 1);

        // Random sets under a sweep of radii; small sets keep the sweep short.
        for (int k = 0; k < 6; k++) begin
            set_radius(radii[k]);
            for (int s = 0; s < 12; s++)
                random_set($urandom_range(1, 16), radii[k]);
        end
        // One denser set under a mid radius.
        set_radius(15'd300);
        random_set(24, 15'd300);

        s_tvalid <= 0;
        while (pending_sets != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/iscc_pkg.sv
hw/rtl/interval_stabbing_cover_count_unit.sv
tb/interval_stabbing_cover_count_checker.sv
tb/interval_stabbing_cover_count_unit_test.sv
